>>> design/mts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the MML token scanner.
// Depends on nothing; imported by every module of the block.
package mts_pkg;

  // Defaults and queue depths (depths must be powers of two)
  localparam int MaxTokenChars = 7;
  localparam int FrontDepth    = 2;
  localparam int TokDepth      = 4;
  localparam int ValueW        = 24;
  localparam logic [ValueW-1:0] ValueMax = {ValueW{1'b1}};

  // Characters of interest
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharSpace = " ";
  localparam logic [7:0] CharT     = "T";
  localparam logic [7:0] CharO     = "O";
  localparam logic [7:0] CharR     = "R";
  localparam logic [7:0] CharA     = "A";
  localparam logic [7:0] CharG     = "G";
  localparam logic [7:0] CharPlus  = "+";
  localparam logic [7:0] CharMinus = "-";
  localparam logic [7:0] CharDot   = ".";
  localparam logic [7:0] Char0     = "0";
  localparam logic [7:0] Char9     = "9";

  // Character classes decided in the front part
  typedef enum logic [3:0] {
    CL_NUL,
    CL_SPACE,
    CL_TEMPO,
    CL_OCTAVE,
    CL_REST,
    CL_LETTER,
    CL_SIGN,
    CL_DIGIT,
    CL_DOT,
    CL_OTHER
  } char_class_e;

  // Token kinds as seen on the result port
  typedef enum logic [2:0] {
    KIND_TEMPO    = 3'd0,
    KIND_OCTAVE   = 3'd1,
    KIND_NOTE     = 3'd2,
    KIND_REST     = 3'd3,
    KIND_NUMBER   = 3'd4,
    KIND_END      = 3'd5,
    KIND_UNKNOWN  = 3'd6,
    KIND_OVERFLOW = 3'd7
  } token_kind_e;

  // Classified character word between front and back
  typedef struct packed {
    char_class_e cls;
    logic [7:0]  ch;
  } char_word_t;

  // Result token word
  typedef struct packed {
    token_kind_e       kind;
    logic [7:0]        lead;
    logic [7:0]        acc;
    logic [ValueW-1:0] value;
    logic [2:0]        len;
    logic              last;
  } token_t;

  function automatic char_class_e classify(input logic [7:0] c);
    char_class_e cls;
    if (c == CharNul) cls = CL_NUL;
    else if (c == CharSpace) cls = CL_SPACE;
    else if (c == CharT) cls = CL_TEMPO;
    else if (c == CharO) cls = CL_OCTAVE;
    else if (c == CharR) cls = CL_REST;
    else if (c >= CharA && c <= CharG) cls = CL_LETTER;
    else if (c == CharPlus || c == CharMinus) cls = CL_SIGN;
    else if (c >= Char0 && c <= Char9) cls = CL_DIGIT;
    else if (c == CharDot) cls = CL_DOT;
    else cls = CL_OTHER;
    return cls;
  endfunction

endpackage

>>> design/mts_front.sv
`timescale 1ns / 1ps
// Front part: accepts character bytes, classifies them and holds them in a
// short queue for the scanner. Depends on mts_pkg.
module mts_front import mts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] byte_i,
  output logic       word_valid_o,
  output char_word_t word_o,
  input  logic       word_take_i
);

  localparam int AW = (FrontDepth > 1) ? $clog2(FrontDepth) : 1;
  localparam int CW = $clog2(FrontDepth + 1);

  char_word_t     mem_q [FrontDepth];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           push_ok, take_ok;

  // Handshake
  assign full    = (cnt_q == CW'(FrontDepth));
  assign push_ok = push && !full;
  assign take_ok = word_take_i && (cnt_q != '0);

  assign word_valid_o = (cnt_q != '0);
  assign word_o       = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push_ok ? wr_ptr_q + AW'(1) : wr_ptr_q;
    rd_ptr_d = take_ok ? rd_ptr_q + AW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CW'(push_ok) - CW'(take_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store classified word
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= '{cls: classify(byte_i), ch: byte_i};
    end
  end

endmodule

>>> design/mts_back.sv
`timescale 1ns / 1ps
// Back part: pending-token scanner and the result token queue.
// Depends on mts_pkg.
module mts_back import mts_pkg::*; #(
  parameter int MAX_TOKEN_CHARS = MaxTokenChars
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       word_valid_i,
  input  char_word_t word_i,
  output logic       word_take_o,
  input  logic       pop,
  output logic       empty,
  output token_t     tok_o
);

  localparam int RunW = $clog2(MAX_TOKEN_CHARS + 1);
  localparam int AW   = $clog2(TokDepth);
  localparam int CW   = $clog2(TokDepth + 1);
  localparam int MacW = ValueW + 4;

  localparam logic [1:0] PEND_NONE   = 2'd0;
  localparam logic [1:0] PEND_NOTE   = 2'd1;
  localparam logic [1:0] PEND_NUMBER = 2'd2;

  // Scanner state
  logic [1:0]        pend_kind_q, pend_kind_d, pend_kind_n;
  logic [7:0]        pend_lead_q, pend_lead_d, pend_lead_n;
  logic [ValueW-1:0] digit_q, digit_d, digit_n;
  logic              dot_q, dot_d, dot_n;
  logic [RunW-1:0]   run_q, run_d, run_n;
  logic              skip_q, skip_d, skip_n;

  // Token queue
  token_t            tok_mem_q [TokDepth];
  logic [AW-1:0]     wp_q, rp_q;
  logic [CW-1:0]     cnt_q, cnt_d;

  logic              fire, has_pend, fl_v, sec_v, pop_ok;
  token_t            fl_tok, sec_tok;
  logic [7:0]        c;
  char_class_e       cls;
  logic [RunW+2:0]   run_ext;
  logic [2:0]        run_len;
  logic [MacW-1:0]   mac;

  function automatic token_t mk_tok(input token_kind_e kind, input logic [7:0] lead,
                                    input logic [7:0] acc);
    token_t t;
    t.kind  = kind;
    t.lead  = lead;
    t.acc   = acc;
    t.value = '0;
    t.len   = '0;
    t.last  = 1'b0;
    return t;
  endfunction

  // Take a word only when two queue slots are free
  assign fire        = word_valid_i && (cnt_q <= CW'(TokDepth - 2));
  assign word_take_o = fire;
  assign c           = word_i.ch;
  assign cls         = word_i.cls;
  assign has_pend    = (pend_kind_q == PEND_NOTE) || (pend_kind_q == PEND_NUMBER);

  // Reported length saturates at 7
  assign run_ext = (RunW + 3)'(run_q);
  assign run_len = (run_ext > (RunW + 3)'(7)) ? 3'd7 : run_ext[2:0];

  // Decimal accumulate: value * 10 + digit
  assign mac = (MacW'(digit_q) << 3) + (MacW'(digit_q) << 1) + MacW'(c[3:0]);

  // Token held by a flush of the pending state; last unless a second token follows
  always_comb begin
    fl_tok       = mk_tok((pend_kind_q == PEND_NOTE) ? KIND_NOTE : KIND_NUMBER,
                          pend_lead_q, 8'h00);
    fl_tok.value = digit_q;
    fl_tok.len   = (pend_kind_q == PEND_NUMBER) ? run_len : 3'd0;
    fl_tok.last  = !sec_v;
  end

  // Scan step for the word at the head of the front queue
  always_comb begin
    pend_kind_n = pend_kind_q;
    pend_lead_n = pend_lead_q;
    digit_n     = digit_q;
    dot_n       = dot_q;
    run_n       = run_q;
    skip_n      = skip_q;
    fl_v        = 1'b0;
    sec_v       = 1'b0;
    sec_tok     = mk_tok(KIND_END, 8'h00, 8'h00);

    if (skip_q) begin
      // Ignore everything after an error until the terminator
      if (cls == CL_NUL) begin
        skip_n      = 1'b0;
        pend_kind_n = PEND_NONE;
        pend_lead_n = '0;
        digit_n     = '0;
        dot_n       = 1'b0;
        run_n       = '0;
        sec_v       = 1'b1;
      end
    end else if (cls == CL_NUL) begin
      fl_v        = has_pend;
      pend_kind_n = PEND_NONE;
      pend_lead_n = '0;
      digit_n     = '0;
      dot_n       = 1'b0;
      run_n       = '0;
      sec_v       = 1'b1;
    end else if (pend_kind_q == PEND_NOTE && cls == CL_SIGN) begin
      // Accidental directly after a note
      sec_v       = 1'b1;
      sec_tok     = mk_tok(KIND_NOTE, pend_lead_q, c);
      pend_kind_n = PEND_NONE;
      pend_lead_n = '0;
    end else if (pend_kind_q == PEND_NUMBER && (cls == CL_DIGIT || cls == CL_DOT)) begin
      if (run_q < RunW'(MAX_TOKEN_CHARS)) begin
        run_n = run_q + RunW'(1);
        if (cls == CL_DOT) begin
          dot_n = 1'b1;
        end else if (!dot_q) begin
          digit_n = (mac > MacW'(ValueMax)) ? ValueMax : mac[ValueW-1:0];
        end
      end else begin
        pend_kind_n = PEND_NONE;
        pend_lead_n = '0;
        digit_n     = '0;
        dot_n       = 1'b0;
        run_n       = '0;
        skip_n      = 1'b1;
        sec_v       = 1'b1;
        sec_tok     = mk_tok(KIND_OVERFLOW, c, 8'h00);
      end
    end else begin
      // Flush what is pending, then start on this character
      fl_v        = has_pend;
      pend_kind_n = PEND_NONE;
      pend_lead_n = '0;
      digit_n     = '0;
      dot_n       = 1'b0;
      run_n       = '0;
      case (cls) inside
        CL_SPACE: ;
        CL_TEMPO: begin
          sec_v   = 1'b1;
          sec_tok = mk_tok(KIND_TEMPO, c, 8'h00);
        end
        CL_OCTAVE: begin
          sec_v   = 1'b1;
          sec_tok = mk_tok(KIND_OCTAVE, c, 8'h00);
        end
        CL_REST: begin
          sec_v   = 1'b1;
          sec_tok = mk_tok(KIND_REST, c, 8'h00);
        end
        CL_LETTER, CL_SIGN: begin
          pend_kind_n = PEND_NOTE;
          pend_lead_n = c;
        end
        CL_DIGIT, CL_DOT: begin
          pend_kind_n = PEND_NUMBER;
          pend_lead_n = c;
          run_n       = RunW'(1);
          dot_n       = (cls == CL_DOT);
          digit_n     = (cls == CL_DOT) ? '0 : ValueW'(c[3:0]);
        end
        default: begin
          skip_n  = 1'b1;
          sec_v   = 1'b1;
          sec_tok = mk_tok(KIND_UNKNOWN, c, 8'h00);
        end
      endcase
    end

    sec_tok.last = 1'b1;
  end

  // Commit state only for a taken word
  always_comb begin
    pend_kind_d = fire ? pend_kind_n : pend_kind_q;
    pend_lead_d = fire ? pend_lead_n : pend_lead_q;
    digit_d     = fire ? digit_n     : digit_q;
    dot_d       = fire ? dot_n       : dot_q;
    run_d       = fire ? run_n       : run_q;
    skip_d      = fire ? skip_n      : skip_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_kind_q <= PEND_NONE;
      pend_lead_q <= '0;
      digit_q     <= '0;
      dot_q       <= 1'b0;
      run_q       <= '0;
      skip_q      <= 1'b0;
    end else begin
      pend_kind_q <= pend_kind_d;
      pend_lead_q <= pend_lead_d;
      digit_q     <= digit_d;
      dot_q       <= dot_d;
      run_q       <= run_d;
      skip_q      <= skip_d;
    end
  end

  // Result queue: up to two writes, one read per cycle
  assign pop_ok = pop && (cnt_q != '0);
  assign empty  = (cnt_q == '0);
  assign tok_o  = tok_mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q - CW'(pop_ok);
    if (fire) begin
      cnt_d = cnt_d + CW'(fl_v) + CW'(sec_v);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (fire) begin
        wp_q <= wp_q + AW'(fl_v) + AW'(sec_v);
      end
      if (pop_ok) begin
        rp_q <= rp_q + AW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      if (fl_v) begin
        tok_mem_q[wp_q] <= fl_tok;
      end
      if (sec_v) begin
        tok_mem_q[fl_v ? wp_q + AW'(1) : wp_q] <= sec_tok;
      end
    end
  end

  // Checks
  a_skip_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q |-> (pend_kind_q == PEND_NONE))
    else $error("pending token survives an error");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TokDepth))
    else $error("result queue overfilled");

  a_run_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_kind_q == PEND_NUMBER) |-> (run_q != '0 && run_q <= RunW'(MAX_TOKEN_CHARS)))
    else $error("number run length out of range");

  a_run_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_kind_q != PEND_NUMBER) |-> (run_q == '0 && digit_q == '0 && !dot_q))
    else $error("number state left over");

  a_take_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (cnt_q <= CW'(TokDepth)) && (cnt_q + CW'(1) >= $past(cnt_q)))
    else $error("queue count moved wrongly after a take");

endmodule

>>> design/mml_token_scanner_unit.sv
`timescale 1ns / 1ps
// Top level of the MML token scanner: front classifier queue feeding the
// scanner and result queue. Depends on mts_pkg, mts_front, mts_back.
//
//  channel  | handshake          | word
//  ---------+--------------------+----------------------------------------------
//  input    | push / full        | in_byte_i
//  result   | empty / pop        | token_kind_o, lead_char_o, accidental_char_o,
//           |                    | number_value_o, number_length_o, last_of_input_o
//
// One byte per cycle is accepted while full is low; a byte's tokens reach the
// result ports through the front queue and then the result queue.
// The scanner takes a byte only when the four-entry result queue has two free
// slots, so a stalled pop backs up into the two-entry front queue and then full.
// With three or more tokens waiting the scanner stalls, since a byte can give two.
// Reset clears both queues and the scanner state; no clearing pass is needed.
module mml_token_scanner_unit import mts_pkg::*; #(
  parameter int MAX_TOKEN_CHARS = MaxTokenChars
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         token_kind_o,
  output logic [7:0]         lead_char_o,
  output logic [7:0]         accidental_char_o,
  output logic signed [24:0] number_value_o,
  output logic [2:0]         number_length_o,
  output logic               last_of_input_o
);

  char_word_t word;
  logic       word_valid, word_take;
  token_t     tok;

  mts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .byte_i      (in_byte_i),
    .word_valid_o(word_valid),
    .word_o      (word),
    .word_take_i (word_take)
  );

  mts_back #(
    .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_valid_i(word_valid),
    .word_i      (word),
    .word_take_o (word_take),
    .pop         (pop),
    .empty       (empty),
    .tok_o       (tok)
  );

  // Result fields; value reads -1 for everything but numbers
  assign token_kind_o      = tok.kind;
  assign lead_char_o       = tok.lead;
  assign accidental_char_o = tok.acc;
  assign number_value_o    = (tok.kind == KIND_NUMBER) ? {1'b0, tok.value} : '1;
  assign number_length_o   = tok.len;
  assign last_of_input_o   = tok.last;

endmodule
